>>> rtl/core/softmax_weighted_token_pooling_core_macros.svh
// Assertion macros shared by the checker of the softmax pooling core.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef SOFTMAX_WEIGHTED_TOKEN_POOLING_CORE_MACROS_SVH
`define SOFTMAX_WEIGHTED_TOKEN_POOLING_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/swp_pkg.sv
// Package of the softmax pooling core: widths, queue sizing, exp tables and word types.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps

package swp_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CFG_W = 10;
    localparam int DATA_W = 16;
    localparam int SCORE_W = 17;
    localparam int ESUM_W = 24;
    localparam int WSUM_W = 40;
    localparam int W_W = 16;
    localparam logic [W_W-1:0] W_ONE = 16'hFFFF;
    localparam logic [CFG_W-1:0] COLS_RESET = 10'd512;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [COL_W-1:0]          column;
        logic signed [DATA_W-1:0]  value;
        logic signed [SCORE_W-1:0] score;
        logic                      first;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] run_max;
        logic [ESUM_W-1:0]         exp_sum;
        logic signed [WSUM_W-1:0]  wsum;
    } col_state_t;

    typedef struct packed {
        logic [COL_W-1:0]         column;
        logic signed [WSUM_W-1:0] num;
        logic [ESUM_W-1:0]        den;
    } div_req_t;

    function automatic logic [16:0] int_tab(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] frac_tab(input logic [3:0] a);
        logic [16:0] v;
        case (a)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/softmax_weighted_token_pooling_core.sv
// Top level of the softmax pooling core: front end, execution pipeline and divider.
// Depends on swp_pkg, swp_front, swp_exec and swp_div.
//
//   channel | signals                                      | width of word
//   cfg     | cfg_valid, cfg_ready, cfg_data               | 10
//   in      | in_valid, in_ready, column .. last_token     | 9 + 3x16 + 2
//   out     | out_valid, out_ready, out_column, pooled_value | 9 + 16
//
// One word per cycle enters while the queue has room; a word then passes through the state
// read and three multiply stages of the execution pipeline.
// A word for a column still in the pipeline waits until that column is written back.
// A chunk end goes through the bit-serial divider, which skips the division when the sum is empty or
// the quotient saturates; the pipeline stalls only when a second chunk end arrives while
// the divider is busy or while its result word waits for out_ready.
// Reset clears control only; the column state is written by each chunk's first word.
`timescale 1ns / 1ps

module softmax_weighted_token_pooling_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swp_pkg::COL_W-1:0]         column,
    input  logic signed [swp_pkg::DATA_W-1:0] token_value,
    input  logic signed [swp_pkg::DATA_W-1:0] token_score,
    input  logic signed [swp_pkg::DATA_W-1:0] position_bias,
    input  logic                              first_token,
    input  logic                              last_token,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swp_pkg::COL_W-1:0]         out_column,
    output logic signed [swp_pkg::DATA_W-1:0] pooled_value
);

    logic              q_valid, q_pop, div_valid, div_ready;
    swp_pkg::item_t    q_item;
    swp_pkg::div_req_t div_req;

    swp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column        (column),
        .token_value   (token_value),
        .token_score   (token_score),
        .position_bias (position_bias),
        .first_token   (first_token),
        .last_token    (last_token),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    swp_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_valid (div_valid),
        .div_req   (div_req),
        .div_ready (div_ready)
    );

    swp_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (div_valid),
        .req          (div_req),
        .req_ready    (div_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_column   (out_column),
        .pooled_value (pooled_value)
    );

endmodule

>>> rtl/core/swp_front.sv
// Front end: configuration register, input word acceptance, column filter and score sum.
// Feeds a small queue toward the execution pipeline. Depends on swp_pkg.
`timescale 1ns / 1ps

module swp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swp_pkg::COL_W-1:0]         column,
    input  logic signed [swp_pkg::DATA_W-1:0] token_value,
    input  logic signed [swp_pkg::DATA_W-1:0] token_score,
    input  logic signed [swp_pkg::DATA_W-1:0] position_bias,
    input  logic                              first_token,
    input  logic                              last_token,
    output logic                              q_valid,
    output swp_pkg::item_t                    q_item,
    input  logic                              q_pop
);

    logic [swp_pkg::CFG_W-1:0]  cols_reg;
    swp_pkg::item_t             qmem_reg [swp_pkg::QUEUE_DEPTH];
    logic [swp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [swp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [swp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       push;
    swp_pkg::item_t             new_item;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg != swp_pkg::QCNT_W'(swp_pkg::QUEUE_DEPTH));
    assign push      = in_valid && in_ready && ({1'b0, column} < cols_reg);
    assign q_valid   = (count_reg != '0);
    assign q_item    = qmem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.column = column;
        new_item.value  = token_value;
        new_item.score  = {token_score[swp_pkg::DATA_W-1], token_score}
                        + {position_bias[swp_pkg::DATA_W-1], position_bias};
        new_item.first  = first_token;
        new_item.last   = last_token;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + swp_pkg::QCNT_W'(push) - swp_pkg::QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= swp_pkg::COLS_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cols_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> rtl/core/swp_exec.sv
// Execution pipeline: per-column state memory, exp weight, rescale and accumulate.
// Takes words from the front queue and hands chunk ends to the divider. Depends on swp_pkg.
`timescale 1ns / 1ps

module swp_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  swp_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               div_valid,
    output swp_pkg::div_req_t  div_req,
    input  logic               div_ready
);

    swp_pkg::col_state_t mem [swp_pkg::MAX_COLUMNS];

    logic b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    swp_pkg::item_t b_item_reg, c_item_reg, d_item_reg, e_item_reg;
    swp_pkg::col_state_t b_st_reg, c_st_reg, d_st_reg, e_st_reg;

    logic        c_gt_reg, c_kzero_reg;
    logic [5:0]  c_r_reg;
    logic [33:0] c_p0_reg;
    logic        d_gt_reg, d_kzero_reg;
    logic [27:0] d_prod_reg;
    logic        e_gt_reg;
    logic [swp_pkg::W_W-1:0] e_wadd_reg;
    logic [39:0]             e_esp_reg;
    logic signed [56:0]      e_wsp_reg;
    logic signed [32:0]      e_vw_reg;

    logic adv, hazard, issue;

    logic signed [17:0] b_diff;
    logic               b_gt, b_kzero;
    logic [17:0]        b_x;
    logic [33:0]        b_p0;

    logic [33:0] c_rnd;
    logic [16:0] c_p;
    logic [27:0] c_prod;

    logic [27:0]             d_rnd;
    logic [17:0]             d_raw;
    logic [swp_pkg::W_W-1:0] d_e, d_wadd;
    logic [39:0]             d_esp;
    logic signed [56:0]      d_wsp;
    logic signed [32:0]      d_vw;

    logic [40:0]                       e_esr;
    logic signed [56:0]                e_wsr;
    logic [swp_pkg::ESUM_W-1:0]        e_es_base;
    logic signed [swp_pkg::WSUM_W-1:0] e_ws_base;
    logic [swp_pkg::ESUM_W:0]          e_es_sum;
    logic signed [swp_pkg::WSUM_W:0]   e_ws_sum;
    swp_pkg::col_state_t               e_new;

    assign adv    = !(e_v_reg && e_item_reg.last && !div_ready);
    assign hazard = (b_v_reg && b_item_reg.column == q_item.column)
                 || (c_v_reg && c_item_reg.column == q_item.column)
                 || (d_v_reg && d_item_reg.column == q_item.column)
                 || (e_v_reg && e_item_reg.column == q_item.column);
    assign issue  = q_valid && adv && !hazard;
    assign q_pop  = issue;

    always_comb
    begin
        b_diff  = {b_item_reg.score[16], b_item_reg.score} - {b_st_reg.run_max[16], b_st_reg.run_max};
        b_gt    = !b_diff[17] && (b_diff != '0);
        b_x     = b_diff[17] ? 18'(-b_diff) : 18'(b_diff);
        b_kzero = (b_x[17:10] >= 8'd12);
        b_p0    = swp_pkg::int_tab(b_x[13:10]) * swp_pkg::frac_tab(b_x[9:6]);

        c_rnd  = c_p0_reg + 34'd32768;
        c_p    = c_rnd[32:16];
        c_prod = c_p * (11'd1024 - {5'd0, c_r_reg});

        d_rnd  = d_prod_reg + 28'd512;
        d_raw  = d_rnd[27:10];
        if (d_kzero_reg)
        begin
            d_e = '0;
        end
        else if (d_raw > 18'(swp_pkg::W_ONE))
        begin
            d_e = swp_pkg::W_ONE;
        end
        else
        begin
            d_e = d_raw[15:0];
        end
        d_wadd = (d_item_reg.first || d_gt_reg) ? swp_pkg::W_ONE : d_e;
        d_esp  = d_st_reg.exp_sum * d_e;
        d_wsp  = d_st_reg.wsum * $signed({1'b0, d_e});
        d_vw   = d_item_reg.value * $signed({1'b0, d_wadd});

        e_esr = {1'b0, e_esp_reg} + 41'd32768;
        e_wsr = e_wsp_reg + 57'sd32768;
        if (e_item_reg.first)
        begin
            e_es_base = '0;
            e_ws_base = '0;
        end
        else if (e_gt_reg)
        begin
            e_es_base = e_esr[39:16];
            e_ws_base = e_wsr[55:16];
        end
        else
        begin
            e_es_base = e_st_reg.exp_sum;
            e_ws_base = e_st_reg.wsum;
        end
        e_es_sum = {1'b0, e_es_base} + {9'd0, e_wadd_reg};
        e_ws_sum = {e_ws_base[39], e_ws_base} + 41'(e_vw_reg);
        e_new.exp_sum = e_es_sum[24] ? '1 : e_es_sum[23:0];
        if (e_ws_sum[40] != e_ws_sum[39])
        begin
            e_new.wsum = e_ws_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            e_new.wsum = e_ws_sum[39:0];
        end
        e_new.run_max = (e_item_reg.first || e_gt_reg) ? e_item_reg.score : e_st_reg.run_max;
    end

    assign div_valid      = e_v_reg && e_item_reg.last;
    assign div_req.column = e_item_reg.column;
    assign div_req.num    = e_new.wsum;
    assign div_req.den    = e_new.exp_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= issue;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg  <= q_item;
            b_st_reg    <= mem[q_item.column];
            c_item_reg  <= b_item_reg;
            c_st_reg    <= b_st_reg;
            c_gt_reg    <= b_gt;
            c_kzero_reg <= b_kzero;
            c_r_reg     <= b_x[5:0];
            c_p0_reg    <= b_p0;
            d_item_reg  <= c_item_reg;
            d_st_reg    <= c_st_reg;
            d_gt_reg    <= c_gt_reg;
            d_kzero_reg <= c_kzero_reg;
            d_prod_reg  <= c_prod;
            e_item_reg  <= d_item_reg;
            e_st_reg    <= d_st_reg;
            e_gt_reg    <= d_gt_reg && !d_item_reg.first;
            e_wadd_reg  <= d_wadd;
            e_esp_reg   <= d_esp;
            e_wsp_reg   <= d_wsp;
            e_vw_reg    <= d_vw;
            if (e_v_reg)
            begin
                mem[e_item_reg.column] <= e_new;
            end
        end
    end

endmodule

>>> rtl/core/swp_div.sv
// Rounding divider for chunk results and the output register of the core.
// Restoring division, one quotient bit per cycle. Depends on swp_pkg.
`timescale 1ns / 1ps

module swp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  swp_pkg::div_req_t                 req,
    output logic                              req_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swp_pkg::COL_W-1:0]         out_column,
    output logic signed [swp_pkg::DATA_W-1:0] pooled_value
);

    typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_HOLD} div_state_t;

    div_state_t                        state_reg, state_next;
    logic [40:0]                       rem_reg, rem_next;
    logic [40:0]                       dsh_reg, dsh_next;
    logic [16:0]                       q_reg, q_next;
    logic [4:0]                        cnt_reg, cnt_next;
    logic                              neg_reg, neg_next;
    logic [swp_pkg::COL_W-1:0]         col_reg, col_next;
    logic signed [swp_pkg::DATA_W-1:0] res_reg, res_next;
    logic                              out_valid_reg, out_valid_next;
    logic [swp_pkg::COL_W-1:0]         out_col_reg, out_col_next;
    logic signed [swp_pkg::DATA_W-1:0] out_val_reg, out_val_next;

    logic [40:0] mag, target, trial;
    logic        fits;

    function automatic logic signed [15:0] clamp(input logic neg, input logic [16:0] q);
        logic signed [15:0] r;
        if (neg)
        begin
            r = (q > 17'd32768) ? -16'sd32768 : 16'(-q);
        end
        else
        begin
            r = (q > 17'd32767) ? 16'sd32767 : 16'(q);
        end
        return r;
    endfunction

    assign req_ready    = (state_reg == DIV_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_column   = out_col_reg;
    assign pooled_value = out_val_reg;

    always_comb
    begin
        mag    = req.num[39] ? 41'(-{req.num[39], req.num}) : {1'b0, req.num};
        target = mag + {18'd0, req.den[23:1]};
        trial  = rem_reg - dsh_reg;
        fits   = (rem_reg >= dsh_reg);

        state_next     = state_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        col_next       = col_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;

        case (state_reg)
            DIV_IDLE:
            begin
                if (req_valid)
                begin
                    neg_next = req.num[39];
                    col_next = req.column;
                    if (req.den == '0)
                    begin
                        res_next   = '0;
                        state_next = DIV_HOLD;
                    end
                    else if (target >= {req.den, 17'd0})
                    begin
                        res_next   = req.num[39] ? -16'sd32768 : 16'sd32767;
                        state_next = DIV_HOLD;
                    end
                    else
                    begin
                        rem_next   = target;
                        dsh_next   = {1'b0, req.den, 16'd0};
                        q_next     = '0;
                        cnt_next   = 5'd16;
                        state_next = DIV_RUN;
                    end
                end
            end
            DIV_RUN:
            begin
                rem_next = fits ? trial : rem_reg;
                q_next   = {q_reg[15:0], fits};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    res_next   = clamp(neg_reg, {q_reg[15:0], fits});
                    state_next = DIV_HOLD;
                end
            end
            DIV_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_val_next   = res_reg;
                    state_next     = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        col_reg     <= col_next;
        res_reg     <= res_next;
        out_col_reg <= out_col_next;
        out_val_reg <= out_val_next;
    end

endmodule

>>> rtl/core/swp_checker.sv
// Port-level checker of the softmax pooling core, bound to the top level.
// Depends on swp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "softmax_weighted_token_pooling_core_macros.svh"

module swp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_ready,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [swp_pkg::COL_W-1:0]         out_column,
    input logic signed [swp_pkg::DATA_W-1:0] pooled_value
);

    `SWP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_column) && $stable(pooled_value), "result word dropped")
    `SWP_ASSERT_IMP(a_no_out_after_reset, !$past(rst_n), !out_valid,
        "result word right after reset")
    `SWP_ASSERT_IMP(a_ready_after_reset, !$past(rst_n), in_ready && cfg_ready,
        "input not ready right after reset")

endmodule

bind softmax_weighted_token_pooling_core swp_checker u_swp_checker (.*);
